// ===== hdl/rtss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record table sort and search package
// Command, result and record types, command and status codes, and the
// sequencer states that the record table uses.
// ----------------------------------------------------------------------------
package rtss_pkg;

    localparam logic [2:0] KIND_LOAD      = 3'd0;
    localparam logic [2:0] KIND_SORT_ASC  = 3'd1;
    localparam logic [2:0] KIND_SORT_DESC = 3'd2;
    localparam logic [2:0] KIND_SEARCH    = 3'd3;
    localparam logic [2:0] KIND_READ_OUT  = 3'd4;

    localparam logic [1:0] STATUS_RECORD    = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic               first;
        logic signed [31:0] key;
        logic [49:0]        phone;
        logic [15:0]        tag;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [49:0]        out_phone;
        logic [15:0]        out_tag;
        logic               last;
    } t_result;

    typedef struct packed {
        logic signed [31:0] key;
        logic [49:0]        phone;
        logic [15:0]        tag;
    } t_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RD_I,
        S_SORT_LD_I,
        S_SORT_RD_J,
        S_SORT_CMP,
        S_SORT_WB,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_END
    } t_state;

endpackage

// ===== hdl/record_table_sort_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record table with exchange sort and linear search
// Holds up to DEPTH records in one RAM and serves load, sort, search and
// read-out commands through a small sequencer around a key order compare and a key match compare.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A load is stored in
// that cycle if the table has room, and leaves busy low. Sort, search and
// read-out raise busy until their last result has been shown; each result
// appears on o_result for one cycle with o_valid high, and the final one
// carries last. The receiver cannot stall, so results are never held back.
// An empty table answers a sort, search or read-out command with one
// empty-status result in the cycle after it is taken, without raising busy.
// Sort runs a compare and swap pass over the stored records on the single
// RAM read port, followed by the read-out.
// Reset clears the record count and the sequencer; stored records are not
// cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module record_table_sort_search
    import rtss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_valid,
    output t_result o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic          r_desc, n_desc;
    logic [31:0]   r_skey, n_skey;
    t_rec          r_hold, n_hold;
    logic          r_have, n_have;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_rec          ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_rec          rd_rec;
    logic          take;
    logic          do_swap;
    logic [CW-1:0] load_base;

    rtss_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_rec)
    );

    assign busy     = (r_state != S_IDLE);
    assign take     = start && !busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign load_base = i_cmd.first ? '0 : r_count;
    assign do_swap   = r_desc ? ($signed(r_hold.key) < $signed(rd_rec.key))
                              : ($signed(r_hold.key) > $signed(rd_rec.key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_have      <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_desc <= n_desc;
        r_skey <= n_skey;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_desc      = r_desc;
        n_skey      = r_skey;
        n_hold      = r_hold;
        n_have      = r_have;
        n_out_valid = 1'b0;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_i[AW-1:0];
        ram_wdata   = r_hold;
        ram_raddr   = r_i[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                n_i    = '0;
                n_have = 1'b0;
                if (take) begin
                    if (i_cmd.kind == KIND_LOAD) begin
                        if (load_base < CW'(DEPTH)) begin
                            ram_we          = 1'b1;
                            ram_waddr       = load_base[AW-1:0];
                            ram_wdata.key   = i_cmd.key;
                            ram_wdata.phone = i_cmd.phone;
                            ram_wdata.tag   = i_cmd.tag;
                            n_count         = load_base + CW'(1);
                        end
                    end else if (i_cmd.kind == KIND_SORT_ASC ||
                                 i_cmd.kind == KIND_SORT_DESC ||
                                 i_cmd.kind == KIND_SEARCH ||
                                 i_cmd.kind == KIND_READ_OUT) begin
                        if (r_count == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.status = STATUS_EMPTY;
                            n_out.last   = 1'b1;
                        end else begin
                            n_desc = (i_cmd.kind == KIND_SORT_DESC);
                            n_skey = i_cmd.key;
                            priority if (i_cmd.kind == KIND_SEARCH) begin
                                n_state = S_SRCH_RD;
                            end else if (i_cmd.kind == KIND_READ_OUT ||
                                         r_count == CW'(1)) begin
                                n_state = S_EMIT_RD;
                            end else begin
                                n_state = S_SORT_RD_I;
                            end
                        end
                    end
                end
            end
            S_SORT_RD_I: begin
                n_state = S_SORT_LD_I;
            end
            S_SORT_LD_I: begin
                n_hold  = rd_rec;
                n_j     = r_i + CW'(1);
                n_state = S_SORT_RD_J;
            end
            S_SORT_RD_J: begin
                ram_raddr = r_j[AW-1:0];
                n_state   = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (do_swap) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[AW-1:0];
                    ram_wdata = r_hold;
                    n_hold    = rd_rec;
                end
                if (r_j + CW'(1) < r_count) begin
                    n_j     = r_j + CW'(1);
                    n_state = S_SORT_RD_J;
                end else begin
                    n_state = S_SORT_WB;
                end
            end
            S_SORT_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[AW-1:0];
                ram_wdata = r_hold;
                if (r_i + CW'(2) < r_count) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SORT_RD_I;
                end else begin
                    n_i     = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                n_out_valid     = 1'b1;
                n_out.status    = STATUS_RECORD;
                n_out.out_key   = rd_rec.key;
                n_out.out_phone = rd_rec.phone;
                n_out.out_tag   = rd_rec.tag;
                n_out.last      = (r_i + CW'(1) == r_count);
                if (r_i + CW'(1) == r_count) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_EMIT_RD;
                end
            end
            S_SRCH_RD: begin
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (rd_rec.key == r_skey) begin
                    if (r_have) begin
                        n_out_valid     = 1'b1;
                        n_out.status    = STATUS_RECORD;
                        n_out.out_key   = r_hold.key;
                        n_out.out_phone = r_hold.phone;
                        n_out.out_tag   = r_hold.tag;
                        n_out.last      = 1'b0;
                    end
                    n_hold = rd_rec;
                    n_have = 1'b1;
                end
                if (r_i + CW'(1) == r_count) begin
                    n_state = S_SRCH_END;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_END: begin
                n_out_valid = 1'b1;
                if (r_have) begin
                    n_out.status    = STATUS_RECORD;
                    n_out.out_key   = r_hold.key;
                    n_out.out_phone = r_hold.phone;
                    n_out.out_tag   = r_hold.tag;
                end else begin
                    n_out        = '0;
                    n_out.status = STATUS_NOT_FOUND;
                end
                n_out.last = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/rtss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtss_ram #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
